@@ src/fht_pkg.sv @@
package fht_pkg;

  // Field widths
  localparam int unsigned TimeW    = 63;
  localparam int unsigned TempW    = 16;
  localparam int unsigned HystW    = 15;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  // Timeouts in microseconds: 16-bit seconds times one million fits in 36 bits
  localparam int unsigned UsPerSW = 20;
  localparam int unsigned LimitW  = CfgDataW + UsPerSW;
  localparam logic [UsPerSW-1:0] UsPerS = 20'd1000000;

  // Reset values of the configuration registers
  localparam logic [LimitW-1:0] SensorLimitRst = 36'd30000000;
  localparam logic [LimitW-1:0] OnLimitRst     = 36'd3600000000;
  localparam logic [HystW-1:0]  HystRst        = 15'd256;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSensorTimeout = 2'd0,
    CfgMaxOn         = 2'd1,
    CfgHysteresis    = 2'd2
  } cfg_idx_e;

  // Configuration as seen by the control logic
  typedef struct packed {
    logic [LimitW-1:0] sensor_limit;
    logic [LimitW-1:0] on_limit;
    logic [HystW-1:0]  hysteresis;
  } cfg_t;

  // One tick item
  typedef struct packed {
    logic [TimeW-1:0]        now_us;
    logic                    on_request;
    logic [TimeW-1:0]        sensor_seen_us;
    logic signed [TempW-1:0] temperature;
    logic signed [TempW-1:0] setpoint;
  } tick_t;

  // One result item
  typedef struct packed {
    logic pulse_valid;
    logic pulse_level;
    logic heater_on;
    logic reading_stale;
    logic on_timeout;
    logic over_temp;
  } result_t;

endpackage

@@ src/fht_cfg.sv @@
module fht_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fht_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [fht_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output fht_pkg::cfg_t                     cfg_o
);
  import fht_pkg::*;

  cfg_t              cfg_d, cfg_q;
  logic [LimitW-1:0] limit_us;

  // Seconds to microseconds, worked out once at write time
  assign limit_us = {{UsPerSW{1'b0}}, cfg_wdata_i} * {{CfgDataW{1'b0}}, UsPerS};

  // Register write decode; unknown index leaves everything as is
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSensorTimeout: cfg_d.sensor_limit = limit_us;
        CfgMaxOn:         cfg_d.on_limit     = limit_us;
        CfgHysteresis:    cfg_d.hysteresis   = cfg_wdata_i[HystW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_limit <= SensorLimitRst;
      cfg_q.on_limit     <= OnLimitRst;
      cfg_q.hysteresis   <= HystRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/fht_core.sv @@
module fht_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  fht_pkg::tick_t    tick_i,
  input  fht_pkg::cfg_t     cfg_i,
  output fht_pkg::result_t  result_o
);
  import fht_pkg::*;

  logic [TimeW-1:0]  on_start_d, on_start_q;
  logic              running_d, running_q;
  logic              timeout_d, timeout_q;
  logic              override_d, override_q;
  logic              driven_d, driven_q;

  logic signed [63:0] sensor_age;
  logic signed [63:0] on_age;
  logic               stale;
  logic               target;
  logic signed [17:0] clear_thr;

  // Signed 64-bit time differences; both operands are below 2^63
  assign sensor_age = $signed({1'b0, tick_i.now_us}) - $signed({1'b0, tick_i.sensor_seen_us});
  assign on_age     = $signed({1'b0, tick_i.now_us}) - $signed({1'b0, on_start_q});

  // Sensor staleness: never reported or report too old
  assign stale = (tick_i.sensor_seen_us == '0) ||
                 (sensor_age > $signed({{(64-LimitW){1'b0}}, cfg_i.sensor_limit}));

  // Lower threshold of the override band
  assign clear_thr = 18'(tick_i.setpoint) - $signed({3'b000, cfg_i.hysteresis});

  // Per-tick state update
  always_comb begin
    on_start_d = on_start_q;
    running_d  = running_q;
    timeout_d  = timeout_q;
    override_d = override_q;

    // On-time failsafe
    priority if (!tick_i.on_request) begin
      on_start_d = '0;
      running_d  = 1'b0;
      timeout_d  = 1'b0;
    end else if (!running_q) begin
      on_start_d = tick_i.now_us;
      running_d  = 1'b1;
    end else if (!timeout_q &&
                 (on_age > $signed({{(64-LimitW){1'b0}}, cfg_i.on_limit}))) begin
      timeout_d = 1'b1;
    end else begin
      timeout_d = timeout_q;
    end

    // Over-temperature override with hysteresis
    priority if (tick_i.temperature >= tick_i.setpoint) begin
      override_d = 1'b1;
    end else if (18'(tick_i.temperature) <= clear_thr) begin
      override_d = 1'b0;
    end else begin
      // inside the band: hold
      override_d = override_q;
    end

    target   = tick_i.on_request && !override_d && !stale && !timeout_d;
    driven_d = target;

    result_o.pulse_valid   = target != driven_q;
    result_o.pulse_level   = (target != driven_q) && target;
    result_o.heater_on     = target;
    result_o.reading_stale = stale;
    result_o.on_timeout    = timeout_d;
    result_o.over_temp     = override_d;
  end

  // Controller state, advanced once per transfer into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_start_q <= '0;
      running_q  <= 1'b0;
      timeout_q  <= 1'b0;
      override_q <= 1'b0;
      driven_q   <= 1'b0;
    end else if (fire_i) begin
      on_start_q <= on_start_d;
      running_q  <= running_d;
      timeout_q  <= timeout_d;
      override_q <= override_d;
      driven_q   <= driven_d;
    end
  end

endmodule

@@ src/failsafe_heater_thermostat.sv @@
// Failsafe heater thermostat, bang-bang control with hysteresis.
// A tick passes from the input register through the combinational control update into
// the result register, from which it transfers out, and ticks can stream back to back.
// Throughput: one tick per cycle unless out_stall_i holds back a full result register.
// Reset (async, active low): heater state, core flags and the on-time clock cleared;
// config back to 30 s sensor timeout, 3600 s max on time, 1.0 degree hysteresis.
module failsafe_heater_thermostat (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [fht_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [fht_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // tick input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fht_pkg::TimeW-1:0]         now_us_i,
  input  logic                              on_request_i,
  input  logic [fht_pkg::TimeW-1:0]         sensor_seen_us_i,
  input  logic signed [fht_pkg::TempW-1:0]  temperature_i,
  input  logic signed [fht_pkg::TempW-1:0]  setpoint_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              pulse_valid_o,
  output logic                              pulse_level_o,
  output logic                              heater_on_o,
  output logic                              reading_stale_o,
  output logic                              on_timeout_o,
  output logic                              over_temp_o
);
  import fht_pkg::*;

  cfg_t    cfg;
  tick_t   tick_q;
  logic    tick_valid_q;
  result_t result_d, result_q;
  logic    out_valid_q;
  logic    out_free;
  logic    fire;

  fht_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: result register frees when empty or taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = tick_valid_q && out_free;
  assign in_stall_o = tick_valid_q && !out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      tick_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      tick_q.now_us         <= now_us_i;
      tick_q.on_request     <= on_request_i;
      tick_q.sensor_seen_us <= sensor_seen_us_i;
      tick_q.temperature    <= temperature_i;
      tick_q.setpoint       <= setpoint_i;
    end
  end

  fht_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .tick_i   (tick_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= tick_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pulse_valid_o   = result_q.pulse_valid;
  assign pulse_level_o   = result_q.pulse_level;
  assign heater_on_o     = result_q.heater_on;
  assign reading_stale_o = result_q.reading_stale;
  assign on_timeout_o    = result_q.on_timeout;
  assign over_temp_o     = result_q.over_temp;

endmodule
